@@ sv/lts_pkg.sv @@
// lts_pkg: shared widths, defaults, request type and rounding helper for the
// log_taylor_series block. No dependencies.
package lts_pkg;

    localparam int MAX_TERMS_DEF = 64;
    localparam int FRAC_BITS_DEF = 30;

    localparam int WORK_BITS = 30;
    localparam int OUT_BITS  = 27;
    localparam int ARG_W     = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 7;
    localparam int DAT_W     = 32;
    localparam int PROD_W    = 64;
    // |sum| stays below 6.2 for up to 255 terms
    localparam int SUM_W     = 36;

    localparam logic [CFG_W-1:0] TERM_RST = 7'd16;

    typedef struct packed {
        logic                    en;
        logic signed [DAT_W-1:0] a;
        logic signed [DAT_W-1:0] b;
    } t_mul_req;

    // drop n fraction bits, round half away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic              neg;
        logic [PROD_W-1:0] m;
        neg = v[PROD_W-1];
        m   = neg ? PROD_W'(-v) : PROD_W'(v);
        if (n != 0) begin
            m = (m + (PROD_W'(1) << (n - 1))) >> n;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

@@ sv/lts_mul.sv @@
// lts_mul: shared signed 32x32 multiplier with registered product.
// Depends on lts_pkg.
module lts_mul (
    input  logic                             i_clk,
    input  lts_pkg::t_mul_req                i_req,
    output logic signed [lts_pkg::PROD_W-1:0] o_prod
);
    import lts_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ sv/lts_rtab.sv @@
// lts_rtab: constant table of rounded reciprocals 1/i, registered read.
// Depends on lts_pkg.
module lts_rtab #(
    parameter  int MAX_TERMS = lts_pkg::MAX_TERMS_DEF,
    localparam int IW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  logic                      i_clk,
    input  logic [IW-1:0]             i_index,
    output logic [lts_pkg::DAT_W-1:0] o_recip
);
    import lts_pkg::*;

    logic [DAT_W-1:0] tab [MAX_TERMS];
    logic [DAT_W-1:0] r_recip;

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tab
        localparam logic [63:0] RV = ((64'd1 << WORK_BITS) + (g + 1) / 2) / (g + 1);
        assign tab[g] = RV[DAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (int'(i_index) < MAX_TERMS) begin
            r_recip <= tab[i_index];
        end else begin
            r_recip <= '0;
        end
    end

    assign o_recip = r_recip;

endmodule

@@ sv/log_taylor_series.sv @@
// log_taylor_series: top level, sequencer around one shared multiplier.
// Depends on lts_pkg, lts_mul, lts_rtab.

// Natural log by truncated Taylor series, ln(x) ~ -sum_{i=1..k} (1-x)^i / i.
// The argument is unsigned with FRAC_BITS fraction bits (saturated at 2.0),
// the result is signed with 27 fraction bits, rounded half away from zero.
// k comes from the term_count register (reset 16, clamped to MAX_TERMS,
// zero gives a result of 0). One request is worked at a time, and the
// input stays not ready until the result has been handed to the output
// register. The single 32x32 multiplier is shared by the terms: per term
// it forms p*(1/i) and then p*u, and the next power is rounded in a state
// of its own before it can feed the multiplier again. A finished result
// waits in the output register while the next request is accepted.
// term_count is written through its own channel, always ready; it is to be
// written only while idle, which the block itself does not enforce.
module log_taylor_series #(
    parameter int MAX_TERMS = lts_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = lts_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lts_pkg::ARG_W-1:0]        i_argument,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [lts_pkg::OUT_W-1:0] o_log_value,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lts_pkg::CFG_W-1:0]        i_term_count
);
    import lts_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;
    localparam int D  = FRAC_BITS - WORK_BITS;
    localparam logic [63:0] X_MAX = 64'd2 << FRAC_BITS;
    localparam logic [63:0] ONE_W = 64'd1 << WORK_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RMUL = 3'd2;
    localparam logic [2:0] ST_UMUL = 3'd3;
    localparam logic [2:0] ST_PUPD = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [CFG_W-1:0]        r_term_count;
    logic [ARG_W-1:0]        r_arg, n_arg;
    logic signed [DAT_W-1:0] r_u, n_u;
    logic signed [DAT_W-1:0] r_p, n_p;
    logic signed [SUM_W-1:0] r_s, n_s;
    logic [CW-1:0]           r_idx, n_idx;
    logic signed [OUT_W-1:0] r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] prod;
    logic [DAT_W-1:0]         recip;
    logic [CW-1:0]            tab_addr;
    logic [KW-1:0]            tc_ext;
    logic [CW-1:0]            k;
    logic [63:0]              x_sat, x_work, u_wide;

    lts_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // table is addressed with the next index so 1/i is ready with r_idx
    assign tab_addr = n_idx - 1'b1;

    lts_rtab #(.MAX_TERMS(MAX_TERMS)) u_rtab (
        .i_clk   (i_clk),
        .i_index (tab_addr[IW-1:0]),
        .o_recip (recip)
    );

    // clamp term count
    assign tc_ext = KW'(r_term_count);
    assign k      = (tc_ext > KW'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(tc_ext);

    // saturate at 2.0 and bring the argument to the working format
    assign x_sat = ({32'b0, r_arg} > X_MAX) ? X_MAX : {32'b0, r_arg};

    if (D > 0) begin : g_down
        assign x_work = (x_sat + (64'd1 << (D - 1))) >> D;
    end else if (D == 0) begin : g_same
        assign x_work = x_sat;
    end else begin : g_up
        assign x_work = x_sat << (-D);
    end

    // u = 1 - x, |u| <= 1
    assign u_wide = ONE_W - x_work;

    always_comb begin
        n_state     = r_state;
        n_arg       = r_arg;
        n_u         = r_u;
        n_p         = r_p;
        n_s         = r_s;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mul_req.en  = 1'b0;
        mul_req.a   = r_p;
        mul_req.b   = r_u;

        // result taken by the sink
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_arg   = i_argument;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_u     = $signed(u_wide[DAT_W-1:0]);
                n_p     = $signed(u_wide[DAT_W-1:0]);
                n_s     = '0;
                n_idx   = CW'(1);
                n_state = (k == '0) ? ST_FIN : ST_RMUL;
            end
            ST_RMUL: begin
                // term product p(i) * 1/i
                mul_req.en = 1'b1;
                mul_req.b  = $signed(recip);
                n_state    = ST_UMUL;
            end
            ST_UMUL: begin
                // subtract term, start next power p(i) * u
                n_s        = r_s - SUM_W'(rnd_shift(prod, WORK_BITS));
                mul_req.en = 1'b1;
                n_state    = (r_idx == k) ? ST_FIN : ST_PUPD;
            end
            ST_PUPD: begin
                n_p     = DAT_W'(rnd_shift(prod, WORK_BITS));
                n_idx   = r_idx + 1'b1;
                n_state = ST_RMUL;
            end
            ST_FIN: begin
                // wait for a free output register
                if (!r_out_valid || i_ready) begin
                    n_out       = OUT_W'(rnd_shift(PROD_W'(r_s), WORK_BITS - OUT_BITS));
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_term_count <= TERM_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_term_count <= i_term_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_arg <= n_arg;
        r_u   <= n_u;
        r_p   <= n_p;
        r_s   <= n_s;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_log_value = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ sv/lts_chk.sv @@
// lts_chk: port-level checker for log_taylor_series, with its bind.
// Depends on lts_pkg and the log_taylor_series ports.
module lts_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [lts_pkg::OUT_W-1:0] o_log_value
);
    import lts_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_log_value)))
        else $error("stalled result changed or dropped");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // busy right after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accepting a request");

    // a result never shows in the cycle after its request
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !$rose(o_valid))
        else $error("result too early after request");

endmodule

bind log_taylor_series lts_chk u_lts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_log_value (o_log_value)
);
